[src/hnm_pkg.sv]
// hnm_pkg: shared types and constants of the height to normal map block
package hnm_pkg;

    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int WCFG_W     = 12;
    localparam int HCFG_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = 16;
    localparam int SUM_W      = 18;
    localparam int TGT_W      = 30;
    localparam int PROD_W     = 34;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WCFG_W-1:0] WIDTH_RESET  = 12'd256;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd256;
    localparam logic [HCFG_W-1:0] MAX_HEIGHT   = 13'd4096;

    // z component is fixed at 102, so its square is fixed too
    localparam logic [SUM_W-1:0] VZ_SQ = 18'd10404;

    typedef enum logic [1:0] {
        RD_PREV_LEFT,
        RD_PREV_CENTER,
        RD_PREV_RIGHT,
        RD_CUR_CENTER
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_UPPER,
        RES_LEFT,
        RES_LAST
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_SETUP_VEC,
        ST_SETUP_SUM,
        ST_SQUARE,
        ST_COMPARE,
        ST_EMIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic       take_item;
        logic       rd_en;
        rd_sel_t    rd_sel;
        logic       cap_en;
        rd_sel_t    cap_sel;
        logic       wr_en;
        logic       setup_vec;
        logic       setup_sum;
        res_t       res_sel;
        logic       square;
        logic       compare;
        logic [2:0] bit_idx;
        logic       load_out;
        logic       last;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic need_upper;
        logic need_left;
        logic need_last;
        logic out_free;
    } status_t;

endpackage

[src/hnm_ctrl.sv]
// hnm_ctrl: sequencer for line buffer access, normal search and result hand-off
module hnm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  hnm_pkg::status_t status,
    output hnm_pkg::cmd_t   cmd
);
    import hnm_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] step_reg, step_next;
    res_t       res_reg, res_next;
    logic       more_after;
    logic       any_need;
    res_t       first_res;
    res_t       after_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
            res_reg   <= RES_UPPER;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        any_need  = status.need_upper || status.need_left || status.need_last;
        first_res = status.need_upper ? RES_UPPER : (status.need_left ? RES_LEFT : RES_LAST);
        case (res_reg)
            RES_UPPER: more_after = status.need_left || status.need_last;
            RES_LEFT:  more_after = status.need_last;
            default:   more_after = 1'b0;
        endcase
        after_res = (res_reg == RES_UPPER && status.need_left) ? RES_LEFT : RES_LAST;
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        res_next     = res_reg;
        in_stall     = 1'b1;
        cmd          = '0;
        cmd.res_sel  = res_reg;
        cmd.bit_idx  = step_reg;
        cmd.rd_sel   = rd_sel_t'(step_reg[1:0]);
        cmd.cap_sel  = rd_sel_t'(step_reg[1:0] - 2'd1);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    step_next     = 3'd0;
                    state_next    = ST_READ;
                end
            end
            ST_READ:
            begin
                // read data lands in the cycle after its address
                cmd.rd_en  = (step_reg != 3'd4);
                cmd.cap_en = (step_reg != 3'd0);
                if (step_reg == 3'd4)
                    state_next = ST_WRITE;
                else
                    step_next = step_reg + 3'd1;
            end
            ST_WRITE:
            begin
                cmd.wr_en = 1'b1;
                if (any_need)
                begin
                    res_next   = first_res;
                    state_next = ST_SETUP_VEC;
                end
                else
                    state_next = ST_FINISH;
            end
            ST_SETUP_VEC:
            begin
                cmd.setup_vec = 1'b1;
                state_next    = ST_SETUP_SUM;
            end
            ST_SETUP_SUM:
            begin
                cmd.setup_sum = 1'b1;
                step_next     = 3'd7;
                state_next    = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                cmd.compare = 1'b1;
                if (step_reg == 3'd0)
                    state_next = ST_EMIT;
                else
                begin
                    step_next  = step_reg - 3'd1;
                    state_next = ST_SQUARE;
                end
            end
            ST_EMIT:
            begin
                cmd.last = !more_after;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (more_after)
                    begin
                        res_next   = after_res;
                        state_next = ST_SETUP_VEC;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_take_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_READ))
        else $error("accepted item did not start the line buffer reads");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("result loaded over an untaken result");

    a_search_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMPARE && step_reg == 3'd0) |=> (state_reg == ST_EMIT))
        else $error("normal search did not end after the last bit");

    a_write_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> ($past(state_reg) == ST_READ))
        else $error("line buffer written before its reads completed");
`endif

endmodule

[src/hnm_datapath.sv]
// hnm_datapath: line buffers, counters, vector setup and bitwise normal search
module hnm_datapath #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [hnm_pkg::PIX_W-1:0]        height_sample,
    input  hnm_pkg::cmd_t                    cmd,
    output hnm_pkg::status_t                 status,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [hnm_pkg::COL_W-1:0]        pixel_col,
    output logic [hnm_pkg::ROW_W-1:0]        pixel_row,
    output logic [hnm_pkg::PIX_W-1:0]        normal_red,
    output logic [hnm_pkg::PIX_W-1:0]        normal_green,
    output logic [hnm_pkg::PIX_W-1:0]        normal_blue,
    output logic [hnm_pkg::PIX_W-1:0]        alpha_height,
    output logic                             last_of_run,
    output logic                             frame_done
);
    import hnm_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(2 * MAX_WIDTH);
    localparam logic [CW:0] MAXW = (CW+1)'(MAX_WIDTH);

    // configuration and position
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic [CW-1:0]     col_count_reg;
    logic [ROW_W-1:0]  row_count_reg;
    logic [CW:0]       w_eff, w_m1;
    logic [HCFG_W-1:0] h_eff, h_m1;

    // line buffers, two row banks
    logic [PIX_W-1:0] mem [0:2*MAX_WIDTH-1];
    logic [PIX_W-1:0] rdata_reg;
    logic [AW-1:0]    rd_addr, wr_addr;

    // item context
    logic [CW-1:0]    x_reg, x_clamp, xm, xp;
    logic [ROW_W-1:0] r_reg, r_clamp;
    logic [PIX_W-1:0] samp_reg, rec0_reg, rec1_reg;
    logic [PIX_W-1:0] pl_reg, pc_reg, pr_reg, cu_reg;
    logic             last_row;

    // vector setup
    logic [PIX_W-1:0] vl, vr, vu, vd, vc;
    logic [CW-1:0]    vcol;
    logic [ROW_W-1:0] vrow;
    logic             vdone;
    logic [PIX_W-1:0] mag_x, mag_y;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [TGT_W-1:0] tgt_reg [3];
    logic             neg_reg [3];
    logic [CW-1:0]    col_res_reg;
    logic [ROW_W-1:0] row_res_reg;
    logic [PIX_W-1:0] alpha_res_reg;
    logic             done_res_reg;

    // search lanes
    logic [7:0]        q_reg [3];
    logic [7:0]        trial [3];
    logic [7:0]        opnd [3];
    logic [SQ_W-1:0]   tsq_reg [3];
    logic [PROD_W-1:0] prod [3];
    logic              pass [3];
    logic [8:0]        up_val [3];
    logic [8:0]        dn_val [3];
    logic [PIX_W-1:0]  chan [3];

    logic out_valid_reg;

    function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [CW-1:0] col);
        logic [AW-1:0] base;
        base = bank ? AW'(MAX_WIDTH) : AW'(0);
        return base + AW'(col);
    endfunction

    always_comb
    begin
        if (width_reg == '0)
            w_eff = (CW+1)'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = MAXW;
        else
            w_eff = (CW+1)'(width_reg);
        if (height_reg == '0)
            h_eff = HCFG_W'(1);
        else if (height_reg > MAX_HEIGHT)
            h_eff = MAX_HEIGHT;
        else
            h_eff = height_reg;
        w_m1 = w_eff - (CW+1)'(1);
        h_m1 = h_eff - HCFG_W'(1);
    end

    assign x_clamp = ({1'b0, col_count_reg} >= w_eff) ? CW'(w_m1) : col_count_reg;
    assign r_clamp = ({1'b0, row_count_reg} >= h_eff) ? ROW_W'(h_m1) : row_count_reg;

    assign xm = (x_reg == '0) ? x_reg : x_reg - CW'(1);
    assign xp = (({1'b0, x_reg} + (CW+1)'(1)) < w_eff) ? x_reg + CW'(1) : CW'(w_m1);

    assign last_row          = ({1'b0, r_reg} == h_m1);
    assign status.need_upper = (r_reg != '0);
    assign status.need_left  = last_row && (x_reg != '0);
    assign status.need_last  = last_row && ({1'b0, x_reg} == w_m1);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV_LEFT:   rd_addr = bank_addr(~r_reg[0], xm);
            RD_PREV_CENTER: rd_addr = bank_addr(~r_reg[0], x_reg);
            RD_PREV_RIGHT:  rd_addr = bank_addr(~r_reg[0], xp);
            RD_CUR_CENTER:  rd_addr = bank_addr(r_reg[0], x_reg);
            default:        rd_addr = bank_addr(r_reg[0], x_reg);
        endcase
        wr_addr = bank_addr(r_reg[0], x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[wr_addr] <= samp_reg;
        if (cmd.rd_en)
            rdata_reg <= mem[rd_addr];
    end

    // config and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_write && cfg_index == CFG_IMAGE_WIDTH)
        begin
            width_reg     <= cfg_data[WCFG_W-1:0];
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_write && cfg_index == CFG_IMAGE_HEIGHT)
        begin
            height_reg    <= cfg_data;
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            if (({1'b0, x_reg} + (CW+1)'(1)) >= w_eff)
            begin
                col_count_reg <= '0;
                if (({1'b0, r_reg} + HCFG_W'(1)) >= h_eff)
                    row_count_reg <= '0;
                else
                    row_count_reg <= r_reg + ROW_W'(1);
            end
            else
            begin
                col_count_reg <= x_reg + CW'(1);
                row_count_reg <= r_reg;
            end
        end
    end

    // item context and neighbor capture
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            x_reg    <= x_clamp;
            r_reg    <= r_clamp;
            samp_reg <= height_sample;
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                RD_PREV_LEFT:   pl_reg <= rdata_reg;
                RD_PREV_CENTER: pc_reg <= rdata_reg;
                RD_PREV_RIGHT:  pr_reg <= rdata_reg;
                RD_CUR_CENTER:  cu_reg <= rdata_reg;
                default:        cu_reg <= rdata_reg;
            endcase
        end
        if (cmd.finish)
        begin
            rec1_reg <= rec0_reg;
            rec0_reg <= samp_reg;
        end
    end

    // neighbor selection for the pixel being finished
    always_comb
    begin
        case (cmd.res_sel)
            RES_UPPER:
            begin
                vl    = pl_reg;
                vr    = pr_reg;
                vu    = (r_reg > ROW_W'(1)) ? cu_reg : pc_reg;
                vd    = samp_reg;
                vc    = pc_reg;
                vcol  = x_reg;
                vrow  = r_reg - ROW_W'(1);
                vdone = 1'b0;
            end
            RES_LEFT:
            begin
                vc    = rec0_reg;
                vl    = (x_reg > CW'(1)) ? rec1_reg : rec0_reg;
                vr    = samp_reg;
                vu    = status.need_upper ? pl_reg : rec0_reg;
                vd    = rec0_reg;
                vcol  = x_reg - CW'(1);
                vrow  = r_reg;
                vdone = 1'b0;
            end
            default:
            begin
                vl    = (x_reg != '0) ? rec0_reg : samp_reg;
                vr    = samp_reg;
                vu    = status.need_upper ? pc_reg : samp_reg;
                vd    = samp_reg;
                vc    = samp_reg;
                vcol  = x_reg;
                vrow  = r_reg;
                vdone = 1'b1;
            end
        endcase
        mag_x = (vl >= vr) ? vl - vr : vr - vl;
        mag_y = (vu >= vd) ? vu - vd : vd - vu;
    end

    // search: count of trial values t with t^2*|v|^2 against 16384*c^2, one bit per pass
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i]  = q_reg[i] | (8'd1 << cmd.bit_idx);
            opnd[i]   = neg_reg[i] ? trial[i] - 8'd1 : trial[i];
            prod[i]   = PROD_W'(tsq_reg[i]) * PROD_W'(sum_reg);
            pass[i]   = neg_reg[i] ? (prod[i] < PROD_W'(tgt_reg[i]))
                                   : (prod[i] <= PROD_W'(tgt_reg[i]));
            up_val[i] = 9'd128 + {1'b0, q_reg[i]};
            dn_val[i] = 9'd128 - {1'b0, q_reg[i]};
            if (neg_reg[i])
                chan[i] = dn_val[i][7:0];
            else
                chan[i] = up_val[i][8] ? 8'd255 : up_val[i][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup_vec)
        begin
            sqx_reg       <= SQ_W'(mag_x) * SQ_W'(mag_x);
            sqy_reg       <= SQ_W'(mag_y) * SQ_W'(mag_y);
            neg_reg[0]    <= (vl < vr);
            neg_reg[1]    <= (vu < vd);
            neg_reg[2]    <= 1'b0;
            col_res_reg   <= vcol;
            row_res_reg   <= vrow;
            alpha_res_reg <= (vc == '0) ? PIX_W'(1) : vc;
            done_res_reg  <= vdone;
        end
        if (cmd.setup_sum)
        begin
            sum_reg    <= SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + VZ_SQ;
            tgt_reg[0] <= {sqx_reg, 14'b0};
            tgt_reg[1] <= {sqy_reg, 14'b0};
            tgt_reg[2] <= TGT_W'({VZ_SQ, 14'b0});
            for (int i = 0; i < 3; i++)
                q_reg[i] <= 8'd0;
        end
        if (cmd.square)
        begin
            for (int i = 0; i < 3; i++)
                tsq_reg[i] <= SQ_W'(opnd[i]) * SQ_W'(opnd[i]);
        end
        if (cmd.compare)
        begin
            for (int i = 0; i < 3; i++)
                if (pass[i])
                    q_reg[i] <= trial[i];
        end
    end

    // output register, frees the search while a result waits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pixel_col    <= COL_W'(col_res_reg);
            pixel_row    <= row_res_reg;
            normal_red   <= chan[0];
            normal_green <= chan[1];
            normal_blue  <= chan[2];
            alpha_height <= alpha_res_reg;
            last_of_run  <= cmd.last;
            frame_done   <= done_res_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/height_to_normal_map.sv]
// height_to_normal_map: top level, a sequencer and its datapath
// an item causes n = 0..3 results; one item at a time
// per result: two setup steps, a bitwise search (8 bits, square then compare)
// and a load of the output register; a finished result may wait there
// while the next item is taken
// reset clears counters and config to 256 x 256; line buffers are not cleared
module height_to_normal_map #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [hnm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hnm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hnm_pkg::PIX_W-1:0]      height_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hnm_pkg::COL_W-1:0]      pixel_col,
    output logic [hnm_pkg::ROW_W-1:0]      pixel_row,
    output logic [hnm_pkg::PIX_W-1:0]      normal_red,
    output logic [hnm_pkg::PIX_W-1:0]      normal_green,
    output logic [hnm_pkg::PIX_W-1:0]      normal_blue,
    output logic [hnm_pkg::PIX_W-1:0]      alpha_height,
    output logic                           last_of_run,
    output logic                           frame_done
);
    import hnm_pkg::*;

    cmd_t    cmd;
    status_t status;

    hnm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hnm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .height_sample (height_sample),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .normal_red    (normal_red),
        .normal_green  (normal_green),
        .normal_blue   (normal_blue),
        .alpha_height  (alpha_height),
        .last_of_run   (last_of_run),
        .frame_done    (frame_done)
    );

endmodule
